### rtl/pccp_pkg.sv
// ----------------------------------------------------------------------------
// pccp_pkg
// Shared types, constants and the arctangent table for the phase current
// Clarke/Park core.
// ----------------------------------------------------------------------------
package pccp_pkg;

    localparam int DEF_ADC_BITS   = 12;
    localparam int DEF_MAX_ROUNDS = 4096;
    localparam int DEF_ANGLE_BITS = 16;

    localparam int INV_SQRT3_Q16 = 37837;
    localparam int CORDIC_K_Q16  = 39797;
    localparam int CORDIC_STEPS  = 14;

    localparam logic [12:0] RST_CALIB_ROUNDS   = 13'd1024;
    localparam logic [23:0] RST_AMPS_PER_COUNT = 24'd65536;

    typedef enum logic [1:0] {
        REG_CALIB_ROUNDS   = 2'd0,
        REG_AMPS_PER_COUNT = 2'd1
    } t_reg_index;

    typedef enum logic [1:0] {
        STATUS_MEASURE = 2'd0,
        STATUS_SAMPLE  = 2'd1,
        STATUS_UPDATED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } t_state;

    // Multiply phases of one measurement request.
    typedef enum logic [2:0] {
        PH_IA,
        PH_IB,
        PH_BETA,
        PH_ID0,
        PH_ID1,
        PH_IQ0,
        PH_IQ1
    } t_phase;

    // Arctangent of 2^-i in units of 1/65536 turn.
    function automatic logic [13:0] cordic_atan(input logic [3:0] i);
        logic [13:0] v;
        unique case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/phase_current_clarke_park_core.sv
// ----------------------------------------------------------------------------
// phase_current_clarke_park_core
// Offset calibration, gain scaling, Clarke and Park transforms on phase
// current samples, with bit-serial multiply, divide and CORDIC.
// ----------------------------------------------------------------------------
// Measurement request: accept, then 7 shift-add multiplies, then the output
// state; most of the time goes to the serial multiplier.
// Calibration request: accept, then output; when the offsets are updated,
// the bit-serial divider runs in between.
// One request at a time; a new request is taken while a result waits.
// Synchronous active-low reset: offsets, sums and count cleared, registers
// set to their reset values.
module phase_current_clarke_park_core #(
    parameter int ADC_BITS   = pccp_pkg::DEF_ADC_BITS,
    parameter int MAX_ROUNDS = pccp_pkg::DEF_MAX_ROUNDS,
    parameter int ANGLE_BITS = pccp_pkg::DEF_ANGLE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_a[11:0], sample_b[23:12], elec_angle[39:24]
    input  logic [39:0]  s_axis_tdata,
    // req_type[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cur_a[31:0], cur_b[63:32], cur_alpha[95:64], cur_beta[127:96],
    // cur_direct[159:128], cur_quad[191:160]
    output logic [191:0] m_axis_tdata,
    // status[1:0], saturated[2]
    output logic [2:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data
);
    import pccp_pkg::*;

    localparam int CNTW  = $clog2(MAX_ROUNDS + 1);
    localparam int SUMW  = ADC_BITS + CNTW;
    localparam int MULW  = 25;
    localparam int STEPW = $clog2((SUMW > MULW) ? SUMW : MULW);
    localparam int RW    = 18;

    t_state r_state, n_state;
    t_phase r_phase;

    logic [12:0]          r_calib_rounds;
    logic [23:0]          r_amps;
    logic [ADC_BITS-1:0]  r_off_a, r_off_b;
    logic [SUMW-1:0]      r_sum_a, r_sum_b;
    logic [CNTW-1:0]      r_cnt;
    logic [STEPW-1:0]     r_step;

    logic [SUMW-1:0]      r_dq_a, r_dq_b;
    logic [CNTW-1:0]      r_rem_a, r_rem_b, r_div;

    logic signed [63:0]   r_acc, r_mcand;
    logic [MULW-1:0]      r_mplier;
    logic signed [31:0]   r_ia, r_ib, r_beta, r_id, r_iq;
    logic                 r_satf;
    logic [ADC_BITS-1:0]  r_sb;
    logic                 r_is_cal;
    t_status              r_res_status;

    logic signed [18:0]   r_cx, r_cy;
    logic signed [16:0]   r_cz;
    logic                 r_cneg, r_cbusy;
    logic [3:0]           r_cstep;

    logic                 r_ovalid;
    logic [191:0]         r_odata;
    logic [2:0]           r_ouser;

    // Input fields.
    logic [ADC_BITS-1:0]   sa, sb;
    logic [ANGLE_BITS-1:0] am;
    logic [15:0]           a16;
    assign sa = ADC_BITS'({{ADC_BITS{1'b0}}, s_axis_tdata[11:0]});
    assign sb = ADC_BITS'({{ADC_BITS{1'b0}}, s_axis_tdata[23:12]});
    assign am = ANGLE_BITS'({{ANGLE_BITS{1'b0}}, s_axis_tdata[39:24]});

    generate
        if (ANGLE_BITS >= 16) begin : g_ang_dn
            assign a16 = 16'(am >> (ANGLE_BITS - 16));
        end else begin : g_ang_up
            assign a16 = {am, {(16 - ANGLE_BITS){1'b0}}};
        end
    endgenerate

    logic accept;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Calibration bookkeeping.
    logic [SUMW-1:0] cal_sum_a, cal_sum_b;
    logic [CNTW-1:0] cal_cnt;
    logic [RW-1:0]   eff_rounds;
    logic            cal_done;
    assign cal_sum_a = r_sum_a + SUMW'(sa);
    assign cal_sum_b = r_sum_b + SUMW'(sb);
    assign cal_cnt   = r_cnt + CNTW'(1);
    always_comb begin
        if (r_calib_rounds == 13'd0) begin
            eff_rounds = RW'(1);
        end else if (RW'(r_calib_rounds) > RW'(MAX_ROUNDS)) begin
            eff_rounds = RW'(MAX_ROUNDS);
        end else begin
            eff_rounds = RW'(r_calib_rounds);
        end
    end
    assign cal_done = (RW'(cal_cnt) >= eff_rounds);

    // Restoring divider, one quotient bit per cycle for each phase.
    logic [CNTW:0] rsh_a, rsh_b;
    logic          qa, qb;
    assign rsh_a = {r_rem_a, r_dq_a[SUMW-1]};
    assign rsh_b = {r_rem_b, r_dq_b[SUMW-1]};
    assign qa    = (rsh_a >= {1'b0, r_div});
    assign qb    = (rsh_b >= {1'b0, r_div});

    // Shift-add multiplier; the top multiplier bit carries negative weight.
    logic signed [63:0] pp, mac_sum, sat_in;
    logic               mac_last, sat_hit;
    logic signed [31:0] sat_val;
    assign pp       = r_mplier[0] ? r_mcand : 64'sd0;
    assign mac_last = (r_step == STEPW'(MULW - 1));
    assign mac_sum  = mac_last ? (r_acc - pp) : (r_acc + pp);
    assign sat_in   = (r_phase == PH_IA || r_phase == PH_IB) ? mac_sum : (mac_sum >>> 16);
    assign sat_hit  = (sat_in > 64'sd2147483647) || (sat_in < -64'sd2147483648);
    assign sat_val  = sat_hit ? (sat_in[63] ? 32'sh80000000 : 32'sh7fffffff)
                              : sat_in[31:0];

    // CORDIC step and final sine/cosine.
    logic signed [18:0] cos_v, sin_v;
    logic signed [16:0] at_v, z0;
    assign at_v  = $signed({3'b000, cordic_atan(r_cstep)});
    assign cos_v = r_cneg ? -r_cx : r_cx;
    assign sin_v = r_cneg ? -r_cy : r_cy;
    assign z0    = 17'($signed(a16));

    logic signed [ADC_BITS:0] da, db;
    assign da = $signed({1'b0, sa}) - $signed({1'b0, r_off_a});
    assign db = $signed({1'b0, r_sb}) - $signed({1'b0, r_off_b});

    // State register and next state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_axis_tuser[0]) begin
                        n_state = ST_MUL;
                    end else if (cal_done) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_DIV: begin
                if (r_step == STEPW'(SUMW - 1)) n_state = ST_FIN;
            end
            ST_MUL: begin
                if (mac_last && r_phase == PH_IQ1) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and calibration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_rounds <= RST_CALIB_ROUNDS;
            r_amps         <= RST_AMPS_PER_COUNT;
            r_off_a        <= '0;
            r_off_b        <= '0;
            r_sum_a        <= '0;
            r_sum_b        <= '0;
            r_cnt          <= '0;
            r_step         <= '0;
            r_phase        <= PH_IA;
            r_cbusy        <= 1'b0;
            r_ovalid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_CALIB_ROUNDS) begin
                    r_calib_rounds <= i_cfg_data[12:0];
                end else if (i_cfg_index == REG_AMPS_PER_COUNT) begin
                    r_amps <= i_cfg_data;
                end
            end

            if (accept && s_axis_tuser[0]) begin
                if (cal_done) begin
                    r_sum_a <= '0;
                    r_sum_b <= '0;
                    r_cnt   <= '0;
                end else begin
                    r_sum_a <= cal_sum_a;
                    r_sum_b <= cal_sum_b;
                    r_cnt   <= cal_cnt;
                end
            end

            if (accept) begin
                r_step  <= '0;
                r_phase <= PH_IA;
                r_cbusy <= !s_axis_tuser[0];
            end else if (r_state == ST_DIV) begin
                r_step <= r_step + STEPW'(1);
                if (r_step == STEPW'(SUMW - 1)) begin
                    r_off_a <= ADC_BITS'({r_dq_a[SUMW-2:0], qa});
                    r_off_b <= ADC_BITS'({r_dq_b[SUMW-2:0], qb});
                end
            end else if (r_state == ST_MUL) begin
                if (mac_last) begin
                    r_step <= '0;
                    if (r_phase != PH_IQ1) r_phase <= t_phase'(r_phase + 3'd1);
                end else begin
                    r_step <= r_step + STEPW'(1);
                end
            end

            if (r_cbusy && r_cstep == 4'(CORDIC_STEPS - 1)) r_cbusy <= 1'b0;

            if (r_state == ST_FIN && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_cal     <= s_axis_tuser[0];
            r_res_status <= cal_done ? STATUS_UPDATED : STATUS_SAMPLE;
            r_sb         <= sb;
            r_satf       <= 1'b0;
            r_acc        <= 64'sd0;
            r_mcand      <= 64'(da);
            r_mplier     <= {1'b0, r_amps};
            r_div        <= cal_cnt;
            r_dq_a       <= cal_sum_a;
            r_dq_b       <= cal_sum_b;
            r_rem_a      <= '0;
            r_rem_b      <= '0;
            r_cx         <= 19'sd39797;
            r_cy         <= 19'sd0;
            r_cstep      <= 4'd0;
            if (z0 > 17'sd16384) begin
                r_cz   <= z0 - 17'sd32768;
                r_cneg <= 1'b1;
            end else if (z0 < -17'sd16384) begin
                r_cz   <= z0 + 17'sd32768;
                r_cneg <= 1'b1;
            end else begin
                r_cz   <= z0;
                r_cneg <= 1'b0;
            end
        end else begin
            if (r_state == ST_DIV) begin
                r_dq_a  <= {r_dq_a[SUMW-2:0], qa};
                r_dq_b  <= {r_dq_b[SUMW-2:0], qb};
                r_rem_a <= qa ? CNTW'(rsh_a - {1'b0, r_div}) : CNTW'(rsh_a);
                r_rem_b <= qb ? CNTW'(rsh_b - {1'b0, r_div}) : CNTW'(rsh_b);
            end

            if (r_cbusy) begin
                r_cstep <= r_cstep + 4'd1;
                if (r_cz >= 0) begin
                    r_cx <= r_cx - (r_cy >>> r_cstep);
                    r_cy <= r_cy + (r_cx >>> r_cstep);
                    r_cz <= r_cz - at_v;
                end else begin
                    r_cx <= r_cx + (r_cy >>> r_cstep);
                    r_cy <= r_cy - (r_cx >>> r_cstep);
                    r_cz <= r_cz + at_v;
                end
            end

            if (r_state == ST_MUL) begin
                if (!mac_last) begin
                    r_acc    <= mac_sum;
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                end else begin
                    unique case (r_phase)
                        PH_IA: begin
                            r_ia     <= sat_val;
                            r_satf   <= r_satf | sat_hit;
                            r_acc    <= 64'sd0;
                            r_mcand  <= 64'(db);
                            r_mplier <= {1'b0, r_amps};
                        end
                        PH_IB: begin
                            r_ib     <= sat_val;
                            r_satf   <= r_satf | sat_hit;
                            r_acc    <= 64'sd32768;
                            r_mcand  <= 64'(r_ia) + (64'(sat_val) <<< 1);
                            r_mplier <= MULW'(INV_SQRT3_Q16);
                        end
                        PH_BETA: begin
                            r_beta   <= sat_val;
                            r_satf   <= r_satf | sat_hit;
                            r_acc    <= 64'sd32768;
                            r_mcand  <= 64'(r_ia);
                            r_mplier <= MULW'(cos_v);
                        end
                        PH_ID0: begin
                            r_acc    <= mac_sum;
                            r_mcand  <= 64'(r_beta);
                            r_mplier <= MULW'(sin_v);
                        end
                        PH_ID1: begin
                            r_id     <= sat_val;
                            r_satf   <= r_satf | sat_hit;
                            r_acc    <= 64'sd32768;
                            r_mcand  <= 64'(r_beta);
                            r_mplier <= MULW'(cos_v);
                        end
                        PH_IQ0: begin
                            r_acc    <= mac_sum;
                            r_mcand  <= -64'(r_ia);
                            r_mplier <= MULW'(sin_v);
                        end
                        PH_IQ1: begin
                            r_iq   <= sat_val;
                            r_satf <= r_satf | sat_hit;
                        end
                        default: r_acc <= mac_sum;
                    endcase
                end
            end
        end

        if (r_state == ST_FIN && (!r_ovalid || m_axis_tready)) begin
            if (r_is_cal) begin
                r_odata <= '0;
                r_ouser <= {1'b0, r_res_status};
            end else begin
                r_odata <= {r_iq, r_id, r_beta, r_ia, r_ib, r_ia};
                r_ouser <= {r_satf, STATUS_MEASURE};
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // The rotation needs sine and cosine, which must be ready by then.
    a_cordic_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_phase == PH_ID0) |-> !r_cbusy)
        else $error("CORDIC still running when the Park multiply starts");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        RW'(r_cnt) <= RW'(MAX_ROUNDS))
        else $error("calibration count above maximum rounds");

    a_div_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt == '0 && r_sum_a == '0 && r_sum_b == '0))
        else $error("calibration sums not restarted during offset update");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_DIV) |-> !s_axis_tready)
        else $error("request accepted while a request is in progress");

endmodule
